[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the pose velocity estimator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/pfdv_pkg.sv]
// Package of the pose velocity estimator: widths, constants, CORDIC angle table.
// Depends on nothing.
package pfdv_pkg;
  localparam int unsigned CordicSteps = 17;
  localparam logic signed [31:0] QOne = 32'sd65536;
  localparam logic signed [31:0] QTwo = 32'sd131072;
  localparam logic signed [31:0] QPi = 32'sd205887;
  localparam logic [29:0] NsPerS = 30'd1000000000;

  function automatic logic signed [17:0] atan_entry(input logic [4:0] idx);
    logic signed [17:0] r;
    unique case (idx)
      5'd0: r = 18'sd51472;
      5'd1: r = 18'sd30386;
      5'd2: r = 18'sd16055;
      5'd3: r = 18'sd8150;
      5'd4: r = 18'sd4091;
      5'd5: r = 18'sd2047;
      5'd6: r = 18'sd1024;
      5'd7: r = 18'sd512;
      5'd8: r = 18'sd256;
      5'd9: r = 18'sd128;
      5'd10: r = 18'sd64;
      5'd11: r = 18'sd32;
      5'd12: r = 18'sd16;
      5'd13: r = 18'sd8;
      5'd14: r = 18'sd4;
      5'd15: r = 18'sd2;
      5'd16: r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_rule(input logic signed [31:0] v);
    return (v > QTwo) ? QOne : v;
  endfunction
endpackage

[hdl/pfdv_cordic.sv]
// Iterative vectoring CORDIC giving atan2 of the quaternion heading terms.
// Depends on pfdv_pkg; one micro-rotation per cycle.
module pfdv_cordic import pfdv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] qx_i,
  input  logic signed [15:0] qy_i,
  input  logic signed [15:0] qz_i,
  input  logic signed [15:0] qw_i,
  output logic               done_o,
  output logic signed [31:0] angle_o
);
  typedef enum logic [1:0] {CIdle, CPrep, CRot, CDone} cstate_e;
  cstate_e st_q;
  logic signed [31:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [52:0] xv_q, yv_q;
  logic signed [31:0] z_q;
  logic [4:0] i_q;
  logic signed [33:0] yv0;
  logic signed [52:0] dx, dy;

  assign yv0 = 34'(pa_q) + 34'(pb_q) - 34'(pc_q) - 34'(pd_q);
  assign dx = yv_q >>> i_q;
  assign dy = xv_q >>> i_q;
  assign done_o = (st_q == CDone);
  assign angle_o = (z_q > QPi) ? QPi : ((z_q < -QPi) ? -QPi : z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CIdle;
      i_q <= '0;
    end else begin
      unique case (st_q)
        CIdle: begin
          if (start_i) begin
            st_q <= CPrep;
            pa_q <= qw_i * qw_i;
            pb_q <= qx_i * qx_i;
            pc_q <= qy_i * qy_i;
            pd_q <= qz_i * qz_i;
            xv_q <= 53'(qx_i * qy_i);
            yv_q <= 53'(qw_i * qz_i);
          end
        end
        CPrep: begin
          // Second pass: the x term is 2(xy+wz), the y term the square sum.
          logic signed [52:0] xt;
          xt = (xv_q + yv_q) <<< 1;
          i_q <= '0;
          if (yv0 == 0 && xt == 0) begin
            z_q <= '0;
            xv_q <= '0;
            yv_q <= '0;
            st_q <= CDone;
          end else begin
            st_q <= CRot;
            if (xt < 0) begin
              z_q <= (yv0 >= 0) ? QPi : -QPi;
              xv_q <= -(xt <<< 16);
              yv_q <= -(53'(yv0) <<< 16);
            end else begin
              z_q <= '0;
              xv_q <= xt <<< 16;
              yv_q <= 53'(yv0) <<< 16;
            end
          end
        end
        CRot: begin
          if (yv_q > 0) begin
            xv_q <= xv_q + dx;
            yv_q <= yv_q - dy;
            z_q <= z_q + 32'(atan_entry(i_q));
          end else begin
            xv_q <= xv_q - dx;
            yv_q <= yv_q + dy;
            z_q <= z_q - 32'(atan_entry(i_q));
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'(CordicSteps - 1)) st_q <= CDone;
        end
        CDone: st_q <= CIdle;
        default: st_q <= CIdle;
      endcase
    end
  end
endmodule

[hdl/pfdv_divider.sv]
// Restoring divider, one quotient bit per cycle, for the velocity quotients.
// Depends on pfdv_pkg; numerator 63 bits, divisor 64 bits unsigned.
module pfdv_divider import pfdv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [62:0] quo_o
);
  logic busy_q, done_q;
  logic [5:0] n_q;
  logic [62:0] q_q;
  logic [64:0] r_q;
  logic [63:0] d_q;
  logic [64:0] sh;
  assign sh = {r_q[63:0], q_q[62]};
  assign done_o = done_q;
  assign quo_o = q_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        q_q <= num_i;
        d_q <= den_i;
        r_q <= '0;
        n_q <= 6'd62;
      end else if (busy_q) begin
        if (sh >= {1'b0, d_q}) begin
          r_q <= sh - {1'b0, d_q};
          q_q <= {q_q[61:0], 1'b1};
        end else begin
          r_q <= sh;
          q_q <= {q_q[61:0], 1'b0};
        end
        if (n_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        n_q <= n_q - 6'd1;
      end
    end
  end
endmodule

[hdl/pose_finite_difference_velocity.sv]
// Top level of the pose velocity estimator: sequencer, reference, output stage.
// Depends on pfdv_pkg, pfdv_cordic, pfdv_divider and assert_macros.svh.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_ready_o  pose, quaternion, stamp
// out       output     out_valid_o/out_ready_i position, heading, rates, interval
//
// The heading CORDIC runs a preparation pass and then its micro-rotations; it skips the
// rotations when both its arguments are zero. Each of four quotients goes to the shared
// divider, which is skipped for a zero difference or gap. The first pose only sets the
// reference and emits nothing; any other item that emits nothing leaves the block ready at once.
// Reset clears the reference and the started flag; no clearing pass is needed.
// The block takes no item while one is in work; a waiting result stalls it.
`include "assert_macros.svh"
module pose_finite_difference_velocity import pfdv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               pose_present_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic [62:0]        stamp_ns_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic signed [31:0] z_out_o,
  output logic signed [18:0] heading_out_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] heading_rate_o,
  output logic signed [63:0] interval_ns_o
);
  typedef enum logic [2:0] {SIdle, SHead, SDiff, SMul, SDiv, SOut} state_e;
  state_e st_q;

  logic started_q, ref_valid_q, first_q;
  logic signed [31:0] ref_x_q, ref_y_q, ref_z_q, ref_h_q;
  logic [63:0] ref_stamp_q;
  logic signed [31:0] px_q, py_q, pz_q, hd_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [62:0] stamp_q;
  logic signed [63:0] itv_q;
  logic [63:0] den_q;
  logic [1:0] k_q;
  logic signed [32:0] diff_q;
  logic [62:0] num_q;
  logic signed [31:0] rate_q [4];
  logic div_start_q, cor_start_q;

  logic cor_done, div_done;
  logic signed [31:0] cor_angle;
  logic [62:0] quo;

  // The current difference quotient's numerator source, chosen by the lane counter.
  logic signed [32:0] diff_sel;
  logic signed [32:0] abs_diff;
  logic neg;
  logic signed [31:0] sat_rate;
  logic signed [33:0] xs;

  pfdv_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start_q),
    .qx_i(qx_q), .qy_i(qy_q), .qz_i(qz_q), .qw_i(qw_q),
    .done_o(cor_done), .angle_o(cor_angle)
  );

  pfdv_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start_q),
    .num_i(num_q), .den_i(den_q), .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    unique case (k_q)
      2'd0: diff_sel = 33'(px_q) - 33'(ref_x_q);
      2'd1: diff_sel = 33'(py_q) - 33'(ref_y_q);
      2'd2: diff_sel = 33'(pz_q) - 33'(ref_z_q);
      default: diff_sel = 33'(hd_q) - 33'(ref_h_q);
    endcase
  end

  assign abs_diff = diff_q[32] ? -diff_q : diff_q;
  assign neg = diff_q[32] ^ itv_q[63];
  // Quotient saturation; the numerator stays below 2^63 so the quotient fits 63 bits.
  always_comb begin
    if (neg) sat_rate = (quo > 63'd2147483648) ? 32'sh80000000 : 32'(-$signed({1'b0, quo}));
    else sat_rate = (quo > 63'd2147483647) ? 32'sh7fffffff : 32'(quo);
  end
  assign xs = 34'(pos_x_i) + 34'(QOne);

  assign in_ready_o = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign x_out_o = clamp_rule(px_q);
  assign y_out_o = clamp_rule(py_q);
  assign z_out_o = clamp_rule(pz_q);
  assign heading_out_o = 19'(clamp_rule(hd_q));
  assign vel_x_o = clamp_rule(rate_q[0]);
  assign vel_y_o = clamp_rule(rate_q[1]);
  assign vel_z_o = clamp_rule(rate_q[2]);
  assign heading_rate_o = clamp_rule(rate_q[3]);
  assign interval_ns_o = itv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      started_q <= 1'b0;
      ref_valid_q <= 1'b0;
      first_q <= 1'b0;
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
      ref_h_q <= '0;
      ref_stamp_q <= '0;
      cor_start_q <= 1'b0;
      div_start_q <= 1'b0;
      k_q <= '0;
    end else begin
      cor_start_q <= 1'b0;
      div_start_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (in_valid_i) begin
            px_q <= pos_x_i;
            py_q <= pos_y_i;
            pz_q <= pos_z_i;
            qx_q <= quat_x_i;
            qy_q <= quat_y_i;
            qz_q <= quat_z_i;
            qw_q <= quat_w_i;
            stamp_q <= stamp_ns_i;
            itv_q <= $signed({1'b0, stamp_ns_i}) - $signed(ref_stamp_q);
            if (!started_q) begin
              started_q <= 1'b1;
              if (pose_present_i) begin
                // The first pose becomes the reference with x raised by one.
                first_q <= 1'b1;
                px_q <= (xs > 34'sd2147483647) ? 32'sh7fffffff : 32'(xs);
                cor_start_q <= 1'b1;
                st_q <= SHead;
              end
            end else if (ref_valid_q && pose_present_i && stamp_ns_i != '0) begin
              first_q <= 1'b0;
              cor_start_q <= 1'b1;
              st_q <= SHead;
            end
          end
        end
        SHead: begin
          if (cor_done) begin
            hd_q <= cor_angle;
            k_q <= '0;
            den_q <= itv_q[63] ? 64'(-itv_q) : 64'(itv_q);
            if (first_q) begin
              ref_valid_q <= 1'b1;
              ref_x_q <= px_q;
              ref_y_q <= py_q;
              ref_z_q <= pz_q;
              ref_h_q <= cor_angle;
              ref_stamp_q <= {1'b0, stamp_q};
              st_q <= SIdle;
            end else begin
              st_q <= SDiff;
            end
          end
        end
        SDiff: begin
          diff_q <= diff_sel;
          st_q <= SMul;
        end
        SMul: begin
          if (diff_q == 0) begin
            rate_q[k_q] <= '0;
            k_q <= k_q + 2'd1;
            st_q <= (k_q == 2'd3) ? SOut : SDiff;
          end else if (itv_q == 0) begin
            rate_q[k_q] <= diff_q[32] ? 32'sh80000000 : 32'sh7fffffff;
            k_q <= k_q + 2'd1;
            st_q <= (k_q == 2'd3) ? SOut : SDiff;
          end else begin
            num_q <= 63'(abs_diff[31:0] * NsPerS);
            div_start_q <= 1'b1;
            st_q <= SDiv;
          end
        end
        SDiv: begin
          if (div_done) begin
            rate_q[k_q] <= sat_rate;
            k_q <= k_q + 2'd1;
            st_q <= (k_q == 2'd3) ? SOut : SDiff;
          end
        end
        SOut: begin
          if (out_ready_i) begin
            ref_x_q <= px_q;
            ref_y_q <= py_q;
            ref_z_q <= pz_q;
            ref_h_q <= hd_q;
            ref_stamp_q <= {1'b0, stamp_q};
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_needs_ref, clk_i, rst_ni, out_valid_o, ref_valid_q && started_q)
  `ASSERT_IMPL(a_ready_not_out, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `ASSERT_NEXT(a_out_release, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
endmodule
